>>> rtl/gfbr_pkg.sv
// Shared types, constants and helpers for the gated FIFO burst release block.
package gfbr_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int ID_WIDTH    = 32;
	localparam int MAX_OUT     = 32;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam int RC_W  = 6;
	localparam int CNT_W = $clog2(MAX_OUT + 1);
	localparam int MIN_W = (OCC_W > RC_W) ? OCC_W : RC_W;

	localparam logic [RC_W-1:0] RC_RESET = RC_W'(3);

	typedef enum logic [0:0] {
		OP_ARRIVE = 1'b0,
		OP_SWITCH = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_PASSED   = 3'd0,
		ST_RELEASED = 3'd1,
		ST_OPENED   = 3'd2,
		ST_SHUT     = 3'd3,
		ST_DROPPED  = 3'd4,
		ST_NONE     = 3'd5
	} status_t;

	typedef struct packed {
		op_t                 op;
		logic [ID_WIDTH-1:0] id;
	} cmd_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

>>> rtl/gfbr_front.sv
// Front end: accepts input beats, decodes them into commands, two-entry command queue.
module gfbr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [31:0]         s_axis_tdata,   // [31:0] vehicle_id
	input  logic                s_axis_tuser,   // [0] kind
	output logic                cmd_valid,
	output gfbr_pkg::cmd_t      cmd,
	input  logic                cmd_pop
);

	gfbr_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	gfbr_pkg::cmd_t new_cmd;

	assign s_axis_tready = (count_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign cmd_valid     = (count_q != 2'd0);
	assign cmd           = slot_q[rd_ptr_q];

	always_comb begin
		new_cmd.op = s_axis_tuser ? gfbr_pkg::OP_SWITCH : gfbr_pkg::OP_ARRIVE;
		new_cmd.id = gfbr_pkg::ID_WIDTH'(s_axis_tdata);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/gfbr_back.sv
// Back end: gate state, ID queue memory, release sequencer and output register.
module gfbr_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  gfbr_pkg::cmd_t               cmd,
	output logic                         cmd_pop,
	input  logic [gfbr_pkg::RC_W-1:0]    release_count,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [39:0]                  m_axis_tdata,  // [31:0] item_id, [32] light_open
	output logic [2:0]                   m_axis_tuser,  // [2:0] status
	output logic                         m_axis_tlast
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EMIT
	} state_t;

	state_t                          state_q;
	logic                            gate_q;
	logic [gfbr_pkg::PTR_W-1:0]      head_q;
	logic [gfbr_pkg::PTR_W-1:0]      tail_q;
	logic [gfbr_pkg::OCC_W-1:0]      occ_q;
	logic [gfbr_pkg::CNT_W-1:0]      cnt_q;

	logic [gfbr_pkg::ID_WIDTH-1:0]   mem [gfbr_pkg::QUEUE_DEPTH];
	logic [gfbr_pkg::ID_WIDTH-1:0]   rdata_q;

	logic                            out_valid_q;
	gfbr_pkg::status_t               out_status_q;
	logic [31:0]                     out_id_q;
	logic                            out_light_q;
	logic                            out_last_q;

	logic                            out_free;
	logic                            full;
	logic                            we;
	logic [gfbr_pkg::MIN_W-1:0]      occ_ext;
	logic [gfbr_pkg::MIN_W-1:0]      rc_ext;
	logic [gfbr_pkg::MIN_W-1:0]      n_a;
	logic [gfbr_pkg::MIN_W-1:0]      n_b;

	logic                            emit;
	gfbr_pkg::status_t               emit_status;
	logic [31:0]                     emit_id;
	logic                            emit_light;
	logic                            emit_last;

	assign out_free = !out_valid_q || m_axis_tready;
	assign full     = (occ_q == gfbr_pkg::OCC_W'(gfbr_pkg::QUEUE_DEPTH));
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid && out_free;
	assign we       = cmd_pop && (cmd.op == gfbr_pkg::OP_ARRIVE) && !gate_q && !full;

	// burst length: min(release_count, occupancy, MAX_OUT)
	always_comb begin
		occ_ext = gfbr_pkg::MIN_W'(occ_q);
		rc_ext  = gfbr_pkg::MIN_W'(release_count);
		n_a     = (rc_ext < occ_ext) ? rc_ext : occ_ext;
		n_b     = (n_a > gfbr_pkg::MIN_W'(gfbr_pkg::MAX_OUT)) ?
		          gfbr_pkg::MIN_W'(gfbr_pkg::MAX_OUT) : n_a;
	end

	// beat loaded into the output register this cycle, if any
	always_comb begin
		emit        = 1'b0;
		emit_status = gfbr_pkg::ST_PASSED;
		emit_id     = '0;
		emit_light  = gate_q;
		emit_last   = 1'b1;
		if (state_q == S_EMIT) begin
			emit        = out_free;
			emit_status = gfbr_pkg::ST_RELEASED;
			emit_id     = 32'(rdata_q);
			emit_light  = 1'b0;
			emit_last   = (cnt_q == gfbr_pkg::CNT_W'(1));
		end else if (cmd_pop) begin
			if (cmd.op == gfbr_pkg::OP_ARRIVE) begin
				if (gate_q) begin
					emit    = 1'b1;
					emit_id = 32'(cmd.id);
				end else if (full) begin
					emit        = 1'b1;
					emit_status = gfbr_pkg::ST_DROPPED;
					emit_id     = 32'(cmd.id);
				end
			end else if (gate_q) begin
				emit        = 1'b1;
				emit_status = gfbr_pkg::ST_SHUT;
				emit_light  = 1'b0;
			end else if (occ_q == '0) begin
				emit        = 1'b1;
				emit_status = gfbr_pkg::ST_OPENED;
				emit_light  = 1'b1;
			end else if (release_count == '0) begin
				emit        = 1'b1;
				emit_status = gfbr_pkg::ST_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[tail_q] <= cmd.id;
		end
		rdata_q <= mem[head_q];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_light_q, out_id_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			gate_q       <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			occ_q        <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= gfbr_pkg::ST_PASSED;
			out_id_q     <= '0;
			out_light_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q  <= 1'b1;
				out_status_q <= emit_status;
				out_id_q     <= emit_id;
				out_light_q  <= emit_light;
				out_last_q   <= emit_last;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (we) begin
						tail_q <= gfbr_pkg::next_ptr(tail_q);
						occ_q  <= occ_q + gfbr_pkg::OCC_W'(1);
					end
					if (cmd_pop && (cmd.op == gfbr_pkg::OP_SWITCH)) begin
						if (gate_q) begin
							gate_q <= 1'b0;
						end else if (occ_q == '0) begin
							gate_q <= 1'b1;
						end else if (release_count != '0) begin
							cnt_q   <= gfbr_pkg::CNT_W'(n_b);
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					// rdata_q picks up mem[head_q] at this edge
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						head_q  <= gfbr_pkg::next_ptr(head_q);
						occ_q   <= occ_q - gfbr_pkg::OCC_W'(1);
						cnt_q   <= cnt_q - gfbr_pkg::CNT_W'(1);
						state_q <= (cnt_q == gfbr_pkg::CNT_W'(1)) ? S_IDLE : S_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/gated_fifo_burst_release_core.sv
// Top level: APB register, front end and back end of the gated FIFO burst release block.
// Path: a single-result beat goes from the command queue into the output register; a
// release burst reads each ID in S_READ and emits it in S_EMIT before reading the next.
// Throughput: one input beat per cycle while results drain and no burst runs; a stalled
// output holds the back end; the input stalls once the two-entry command queue fills.
// Reset: clears gate (shut), pointers, occupancy, handshakes; release_count resets to 3.
module gated_fifo_burst_release_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] vehicle_id
	input  logic        s_axis_tuser,   // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] item_id, [32] light_open
	output logic [2:0]  m_axis_tuser,   // [2:0] status
	output logic        m_axis_tlast
);

	logic [gfbr_pkg::RC_W-1:0] release_count_q;
	logic                      cmd_valid;
	gfbr_pkg::cmd_t            cmd;
	logic                      cmd_pop;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(release_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_count_q <= gfbr_pkg::RC_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			release_count_q <= pwdata[gfbr_pkg::RC_W-1:0];
		end
	end

	gfbr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop)
	);

	gfbr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop),
		.release_count (release_count_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
